// ----- src/two_channel_tone_noise_generator_assert.svh -----
// ----------------------------------------------------------------------------
// two_channel_tone_noise_generator_assert.svh
// assertion macros shared by the tone and noise generator modules
// ----------------------------------------------------------------------------
`ifndef TWO_CHANNEL_TONE_NOISE_GENERATOR_ASSERT_SVH
`define TWO_CHANNEL_TONE_NOISE_GENERATOR_ASSERT_SVH

// same-cycle implication, clocked on clk, idle during reset
`define TCG_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tcg assertion failed");

// next-cycle implication, clocked on clk, idle during reset
`define TCG_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tcg assertion failed");

`endif

// ----- src/tcg_pkg.sv -----
// ----------------------------------------------------------------------------
// tcg_pkg
// types, constants and tables of the two-channel tone and noise generator
// ----------------------------------------------------------------------------
package tcg_pkg;

    localparam int unsigned SAMPLE_RATE_HZ = 44100;
    localparam logic [9:0]  ENV_STEP_TICKS = 10'(SAMPLE_RATE_HZ / 100);
    localparam logic [7:0]  NOISE_P0       = 8'(SAMPLE_RATE_HZ / 7000);
    localparam logic [7:0]  NOISE_P1       = 8'(SAMPLE_RATE_HZ / 3500);
    localparam logic [7:0]  NOISE_P2       = 8'(SAMPLE_RATE_HZ / 1750);
    localparam logic [15:0] NOISE_SEED     = 16'h4000;
    localparam logic [13:0] VOL_FULL       = 14'h3fff;
    localparam logic [13:0] VOL_HALF       = 14'h1fff;

    localparam logic MODE_START = 1'b0;
    localparam logic MODE_TICK  = 1'b1;
    localparam logic CH_NOISE   = 1'b0;
    localparam logic CH_TONE    = 1'b1;

    typedef struct packed {
        logic       mode;
        logic [7:0] note;
        logic       channel;
    } cmd_t;

    typedef struct packed {
        logic signed [15:0] sample;
    } audio_t;

    typedef struct packed {
        logic        active;
        logic        expire;
        logic        level;
        logic [13:0] vol;
    } chan_status_t;

    localparam logic [7:0] PERIOD_ROM [0:255] = '{
        8'd178, 8'd176, 8'd173, 8'd171, 8'd168, 8'd166, 8'd163, 8'd161,
        8'd159, 8'd156, 8'd154, 8'd152, 8'd150, 8'd148, 8'd145, 8'd143,
        8'd141, 8'd139, 8'd137, 8'd135, 8'd133, 8'd131, 8'd129, 8'd128,
        8'd126, 8'd124, 8'd122, 8'd120, 8'd119, 8'd117, 8'd115, 8'd114,
        8'd112, 8'd110, 8'd109, 8'd107, 8'd106, 8'd104, 8'd103, 8'd101,
        8'd100, 8'd98,  8'd97,  8'd95,  8'd94,  8'd93,  8'd91,  8'd90,
        8'd89,  8'd88,  8'd86,  8'd85,  8'd84,  8'd83,  8'd81,  8'd80,
        8'd79,  8'd78,  8'd77,  8'd76,  8'd75,  8'd74,  8'd72,  8'd71,
        8'd70,  8'd69,  8'd68,  8'd67,  8'd66,  8'd65,  8'd64,  8'd64,
        8'd63,  8'd62,  8'd61,  8'd60,  8'd59,  8'd58,  8'd57,  8'd57,
        8'd56,  8'd55,  8'd54,  8'd53,  8'd53,  8'd52,  8'd51,  8'd50,
        8'd50,  8'd49,  8'd48,  8'd47,  8'd47,  8'd46,  8'd45,  8'd45,
        8'd44,  8'd44,  8'd43,  8'd42,  8'd42,  8'd41,  8'd40,  8'd40,
        8'd39,  8'd39,  8'd38,  8'd38,  8'd37,  8'd37,  8'd36,  8'd35,
        8'd35,  8'd34,  8'd34,  8'd33,  8'd33,  8'd32,  8'd32,  8'd32,
        8'd31,  8'd31,  8'd30,  8'd30,  8'd29,  8'd29,  8'd28,  8'd28,
        8'd28,  8'd27,  8'd27,  8'd26,  8'd26,  8'd26,  8'd25,  8'd25,
        8'd25,  8'd24,  8'd24,  8'd23,  8'd23,  8'd23,  8'd22,  8'd22,
        8'd22,  8'd22,  8'd21,  8'd21,  8'd21,  8'd20,  8'd20,  8'd20,
        8'd19,  8'd19,  8'd19,  8'd19,  8'd18,  8'd18,  8'd18,  8'd17,
        8'd17,  8'd17,  8'd17,  8'd16,  8'd16,  8'd16,  8'd16,  8'd16,
        8'd15,  8'd15,  8'd15,  8'd15,  8'd14,  8'd14,  8'd14,  8'd14,
        8'd14,  8'd13,  8'd13,  8'd13,  8'd13,  8'd13,  8'd12,  8'd12,
        8'd12,  8'd12,  8'd12,  8'd12,  8'd11,  8'd11,  8'd11,  8'd11,
        8'd11,  8'd11,  8'd10,  8'd10,  8'd10,  8'd10,  8'd10,  8'd10,
        8'd9,   8'd9,   8'd9,   8'd9,   8'd9,   8'd9,   8'd9,   8'd8,
        8'd8,   8'd8,   8'd8,   8'd8,   8'd8,   8'd8,   8'd8,   8'd8,
        8'd7,   8'd7,   8'd7,   8'd7,   8'd7,   8'd7,   8'd7,   8'd7,
        8'd7,   8'd6,   8'd6,   8'd6,   8'd6,   8'd6,   8'd6,   8'd6,
        8'd6,   8'd6,   8'd6,   8'd6,   8'd5,   8'd5,   8'd5,   8'd5,
        8'd5,   8'd5,   8'd5,   8'd5,   8'd5,   8'd5,   8'd5,   8'd5,
        8'd4,   8'd4,   8'd4,   8'd4,   8'd4,   8'd4,   8'd4,   8'd4
    };

    // envelope volume for a channel at a position; out of table reads as zero
    function automatic logic [13:0] env_volume(input logic sel, input logic [4:0] pos);
        logic [13:0] v;
        v = '0;
        if (sel == CH_NOISE) begin
            if (pos == 5'd0 || pos == 5'd19) begin
                v = VOL_HALF;
            end
            else if (pos <= 5'd18) begin
                v = VOL_FULL;
            end
        end
        else begin
            if (pos == 5'd0) begin
                v = VOL_FULL;
            end
            else if (pos == 5'd1) begin
                v = VOL_HALF;
            end
        end
        return v;
    endfunction

    // half period loaded by a start beat
    function automatic logic [7:0] start_period(input logic sel, input logic [7:0] note);
        logic [7:0] p;
        p = '0;
        if (sel == CH_TONE) begin
            p = PERIOD_ROM[note];
        end
        else begin
            unique case (note[1:0])
                2'd0:    p = NOISE_P0;
                2'd1:    p = NOISE_P1;
                2'd2:    p = NOISE_P2;
                default: p = '0;
            endcase
        end
        return p;
    endfunction

endpackage

// ----- src/tcg_stream_if.sv -----
// ----------------------------------------------------------------------------
// tcg_stream_if
// valid/ready channel carrying one payload beat
// ----------------------------------------------------------------------------
interface tcg_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ----- src/tcg_lfsr.sv -----
// ----------------------------------------------------------------------------
// tcg_lfsr
// 16-bit shift-right noise register, feedback of bits 0 and 1 into bit 15
// ----------------------------------------------------------------------------
`include "two_channel_tone_noise_generator_assert.svh"

module tcg_lfsr (
    input  logic clk,
    input  logic rst_n,
    input  logic step,
    output logic next_bit
);

    logic [15:0] lfsr_reg;
    logic [15:0] lfsr_next;

    always_comb
    begin
        lfsr_next = {lfsr_reg[0] ^ lfsr_reg[1], lfsr_reg[15:1]};
    end

    assign next_bit = lfsr_next[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            lfsr_reg <= tcg_pkg::NOISE_SEED;
        end
        else if (step) begin
            lfsr_reg <= lfsr_next;
        end
    end

    `TCG_ASSERT_NOW(a_lfsr_never_zero, 1'b1, lfsr_reg != 16'h0000)

endmodule

// ----- src/tcg_channel.sv -----
// ----------------------------------------------------------------------------
// tcg_channel
// one sound channel: period counter, level, envelope position and tick count
// ----------------------------------------------------------------------------
module tcg_channel (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       noise_sel,
    input  logic                       start,
    input  logic [7:0]                 period,
    input  logic                       tick,
    input  logic                       level_in,
    output tcg_pkg::chan_status_t      status
);

    logic       level_reg,   level_next;
    logic [4:0] pos_reg,     pos_next;
    logic [7:0] cnt_reg,     cnt_next;
    logic [7:0] half_reg,    half_next;
    logic [9:0] elapsed_reg, elapsed_next;

    logic       active;
    logic       expire;
    logic       env_step;
    logic [4:0] pos_adv;
    logic [9:0] elapsed_adj;

    assign active = (half_reg != 8'd0);
    assign expire = active && (cnt_reg == 8'd0);

    assign status.active = active;
    assign status.expire = expire;
    assign status.level  = level_reg;
    assign status.vol    = tcg_pkg::env_volume(noise_sel, pos_reg);

    always_comb
    begin
        env_step     = (elapsed_reg >= tcg_pkg::ENV_STEP_TICKS);
        pos_adv      = env_step ? pos_reg + 5'd1 : pos_reg;
        elapsed_adj  = env_step ? elapsed_reg - tcg_pkg::ENV_STEP_TICKS : elapsed_reg;
        level_next   = level_reg;
        pos_next     = pos_reg;
        cnt_next     = cnt_reg;
        half_next    = half_reg;
        elapsed_next = elapsed_reg;
        if (start) begin
            pos_next  = '0;
            half_next = period;
        end
        else if (tick && active) begin
            if (expire) begin
                level_next = level_in;
                pos_next   = pos_adv;
                if (tcg_pkg::env_volume(noise_sel, pos_adv) == 14'd0) begin
                    half_next = '0;
                end
                cnt_next     = half_next;
                elapsed_next = elapsed_adj + 10'd1;
            end
            else begin
                cnt_next     = cnt_reg - 8'd1;
                elapsed_next = elapsed_reg + 10'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            level_reg   <= 1'b0;
            pos_reg     <= '0;
            cnt_reg     <= '0;
            half_reg    <= '0;
            elapsed_reg <= '0;
        end
        else begin
            level_reg   <= level_next;
            pos_reg     <= pos_next;
            cnt_reg     <= cnt_next;
            half_reg    <= half_next;
            elapsed_reg <= elapsed_next;
        end
    end

endmodule

// ----- src/two_channel_tone_noise_generator.sv -----
// ----------------------------------------------------------------------------
// two_channel_tone_noise_generator
// noise and square tone channels mixed into one signed sample per tick beat
// ----------------------------------------------------------------------------
// A beat is taken on cmd every cycle while cmd is not stalled. Mode start
// loads a channel's half period (tone from the period table, noise from note
// bits 1:0) and gives no beat on audio; mode tick updates both channels and
// gives one sample. A sample reaches audio through the input register, where
// its command waits, then through the channel update into the result register.
// Sustained rate is one beat per cycle, set by that single update pass; cmd
// stalls only while a tick waits for the result register to be taken.
`include "two_channel_tone_noise_generator_assert.svh"

module two_channel_tone_noise_generator (
    input  logic         clk,
    input  logic         rst_n,
    tcg_stream_if.sink   cmd,
    tcg_stream_if.source audio
);

    logic                  s1_valid_reg;
    tcg_pkg::cmd_t         s1_cmd_reg;
    logic                  out_valid_reg;
    logic signed [15:0]    out_sample_reg;

    logic                  out_free;
    logic                  s1_fire;
    logic                  s1_start;
    logic                  tick;
    logic                  start_noise;
    logic                  start_tone;
    logic [7:0]            start_p;
    logic                  lfsr_bit;
    tcg_pkg::chan_status_t noise_st;
    tcg_pkg::chan_status_t tone_st;
    logic [15:0]           noise_c;
    logic [15:0]           tone_c;
    logic [15:0]           mix;

    assign out_free = !out_valid_reg || audio.ready;
    assign s1_fire  = s1_valid_reg
                      && ((s1_cmd_reg.mode == tcg_pkg::MODE_START) || out_free);
    assign s1_start = s1_valid_reg && (s1_cmd_reg.mode == tcg_pkg::MODE_START);
    assign cmd.ready = !s1_valid_reg || s1_fire;

    assign tick        = s1_fire && (s1_cmd_reg.mode == tcg_pkg::MODE_TICK);
    assign start_noise = s1_fire && (s1_cmd_reg.mode == tcg_pkg::MODE_START)
                         && (s1_cmd_reg.channel == tcg_pkg::CH_NOISE);
    assign start_tone  = s1_fire && (s1_cmd_reg.mode == tcg_pkg::MODE_START)
                         && (s1_cmd_reg.channel == tcg_pkg::CH_TONE);
    assign start_p     = tcg_pkg::start_period(s1_cmd_reg.channel, s1_cmd_reg.note);

    tcg_lfsr u_lfsr (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (tick && noise_st.expire),
        .next_bit (lfsr_bit)
    );

    tcg_channel u_noise (
        .clk       (clk),
        .rst_n     (rst_n),
        .noise_sel (tcg_pkg::CH_NOISE),
        .start     (start_noise),
        .period    (start_p),
        .tick      (tick),
        .level_in  (lfsr_bit),
        .status    (noise_st)
    );

    tcg_channel u_tone (
        .clk       (clk),
        .rst_n     (rst_n),
        .noise_sel (tcg_pkg::CH_TONE),
        .start     (start_tone),
        .period    (start_p),
        .tick      (tick),
        .level_in  (!tone_st.level),
        .status    (tone_st)
    );

    // signed contribution of each active channel
    always_comb
    begin
        noise_c = '0;
        tone_c  = '0;
        if (noise_st.active) begin
            noise_c = noise_st.level ? {2'b00, noise_st.vol} : -{2'b00, noise_st.vol};
        end
        if (tone_st.active) begin
            tone_c = tone_st.level ? {2'b00, tone_st.vol} : -{2'b00, tone_st.vol};
        end
        mix = noise_c + tone_c;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else begin
            if (cmd.valid && cmd.ready) begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_fire) begin
                s1_valid_reg <= 1'b0;
            end
            if (out_free) begin
                out_valid_reg <= tick;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready) begin
            s1_cmd_reg <= cmd.payload;
        end
        if (tick) begin
            out_sample_reg <= signed'(mix);
        end
    end

    assign audio.valid          = out_valid_reg;
    assign audio.payload.sample = out_sample_reg;

    `TCG_ASSERT_NEXT(a_tick_gives_beat, tick, out_valid_reg)
    `TCG_ASSERT_NEXT(a_start_is_silent, !out_valid_reg && s1_start, !out_valid_reg)
    `TCG_ASSERT_NOW(a_sample_in_range, out_valid_reg, out_sample_reg != 16'sh8000)

endmodule
